FILE: hw/rtl/rmst_pkg.sv
// Shared constants, types and helpers for the range-max update table.
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

  // Table geometry
  localparam int MAX_POSITIONS = 1024;
  localparam int NUM_LEVELS    = 11;
  localparam int POS_W         = $clog2(MAX_POSITIONS);  // column index, 0-based
  localparam int LVL_W         = $clog2(NUM_LEVELS);
  localparam int ADDR_W        = LVL_W + POS_W;          // {level, column}
  localparam int DEPTH         = NUM_LEVELS * (2 ** POS_W);

  // Field widths
  localparam int FIELD_W  = 11;           // endpoints, position, size register
  localparam int IDX_W    = FIELD_W + 1;  // room for sums of two indexes
  localparam int RAISE_W  = 32;
  localparam int VAL_W    = 30;
  localparam int OP_W     = 2;

  // Request tdata layout, lowest bit first
  localparam int END_A_LSB  = 0;
  localparam int END_B_LSB  = END_A_LSB + FIELD_W;
  localparam int RAISE_LSB  = END_B_LSB + FIELD_W;
  localparam int POS_LSB    = RAISE_LSB + RAISE_W;
  localparam int IN_BITS    = POS_LSB + FIELD_W;
  localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((VAL_W + 7) / 8) * 8;

  localparam logic [FIELD_W-1:0] SIZE_RESET = FIELD_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE   = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_READ     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_REJECTED = 1'b1
  } status_t;

  // floor(log2(len)) by leading-one search, saturated to the top level
  function automatic logic [LVL_W-1:0] floor_log2(input logic [IDX_W-1:0] len);
    logic [LVL_W-1:0] k;
    k = '0;
    for (int b = 0; b < IDX_W; b++) begin
      if (len[b]) begin
        k = (b >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1) : LVL_W'(b);
      end
    end
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] val_max(input logic [VAL_W-1:0] x,
                                               input logic [VAL_W-1:0] y);
    return (x > y) ? x : y;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/range_max_update_sparse_table.sv
// Top level of the range-max update table: sequencer around one table RAM.
`timescale 1ns / 1ps
`default_nettype none

// Range-max update table with deferred push-down.
//
// Requests come in on s_axis_* (opcode in tuser), one result per request
// leaves on m_axis_* (status in tuser). cfg_* writes size_in_use; it is
// always ready and is meant to be written only while the block is idle.
// All levels live in one RAM of NUM_LEVELS x 1024 words, address
// {level, column-1}, with a registered read.
//   update   : two read-modify-writes, then the reply state; a new
//              request is taken only once the sequencer is back in idle.
//   read     : one RAM read and a wait state, then the reply state.
//   rejected : straight to the reply state.
//   finalize : per level and column one source read plus one or two
//              read-modify-writes into the level below.
//   clear    : one word per cycle over all DEPTH (11264) words.
// After reset the same clearing sweep runs with
// s_axis_tready low; config writes are still taken.
// Results go through an output register: the next request is accepted
// while a result waits, but a second result holds the sequencer until
// m_axis_tready frees the register.
module range_max_update_sparse_table (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // requests
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [10:0] end_a, [21:11] end_b, [53:22] raise_value, [64:54] position
  input  wire logic [rmst_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  wire logic [rmst_pkg::OP_W-1:0]        s_axis_tuser,
  // results
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [29:0] read_value
  output logic      [rmst_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] status
  output logic                                  m_axis_tuser,
  // size_in_use register write
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rmst_pkg::FIELD_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_RD1,
    S_UPD_WR1,
    S_UPD_WR2,
    S_RD_WAIT,
    S_FIN_SRC,
    S_FIN_T1,
    S_FIN_W1,
    S_FIN_W2,
    S_REPLY
  } state_t;

  state_t state;

  logic [rmst_pkg::FIELD_W-1:0] size_in_use;
  logic [rmst_pkg::FIELD_W-1:0] eff_size;

  // request fields
  rmst_pkg::op_t                in_op;
  logic [rmst_pkg::FIELD_W-1:0] end_a, end_b, position;
  logic [rmst_pkg::VAL_W-1:0]   in_val;
  logic                         ends_ok, pos_ok;
  logic [rmst_pkg::FIELD_W-1:0] lo_end, hi_end, lo_m1, hi_m1, pos_m1;
  logic                         accept;

  // update registers
  logic [rmst_pkg::POS_W-1:0]   l_idx, r_idx;
  logic [rmst_pkg::VAL_W-1:0]   upd_val;
  logic [rmst_pkg::ADDR_W-1:0]  upd_addr1, upd_addr2;
  logic [rmst_pkg::IDX_W-1:0]   upd_len, upd_idx2;
  logic [rmst_pkg::LVL_W-1:0]   upd_lvl;

  // finalize registers
  logic [rmst_pkg::LVL_W-1:0]   lvl, lvl_lo;
  logic [rmst_pkg::POS_W-1:0]   jj;
  logic [rmst_pkg::VAL_W-1:0]   fin_val;
  logic [rmst_pkg::IDX_W-1:0]   fin_half, fin_tgt;
  logic                         fin_has2, fin_last_col;

  // clearing sweep
  logic [rmst_pkg::ADDR_W-1:0]  clr_addr;
  logic                         clr_reply;
  logic                         clr_last;

  // pending result
  logic [rmst_pkg::VAL_W-1:0]   res_value;
  rmst_pkg::status_t            res_status;

  // RAM port
  logic                         ram_we;
  logic [rmst_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [rmst_pkg::VAL_W-1:0]   ram_wdata, ram_rdata;

  rmst_ram #(
    .WIDTH (rmst_pkg::VAL_W),
    .DEPTH (rmst_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    eff_size = (size_in_use > rmst_pkg::FIELD_W'(rmst_pkg::MAX_POSITIONS))
             ? rmst_pkg::FIELD_W'(rmst_pkg::MAX_POSITIONS) : size_in_use;
  end

  // unpack and range-check the request
  always_comb begin
    in_op    = rmst_pkg::op_t'(s_axis_tuser);
    end_a    = s_axis_tdata[rmst_pkg::END_A_LSB +: rmst_pkg::FIELD_W];
    end_b    = s_axis_tdata[rmst_pkg::END_B_LSB +: rmst_pkg::FIELD_W];
    in_val   = s_axis_tdata[rmst_pkg::RAISE_LSB +: rmst_pkg::VAL_W];
    position = s_axis_tdata[rmst_pkg::POS_LSB +: rmst_pkg::FIELD_W];
    ends_ok  = (end_a != '0) && (end_a <= eff_size)
            && (end_b != '0) && (end_b <= eff_size);
    pos_ok   = (position != '0) && (position <= eff_size);
    lo_end   = (end_a < end_b) ? end_a : end_b;
    hi_end   = (end_a < end_b) ? end_b : end_a;
    lo_m1    = lo_end - rmst_pkg::FIELD_W'(1);
    hi_m1    = hi_end - rmst_pkg::FIELD_W'(1);
    pos_m1   = position - rmst_pkg::FIELD_W'(1);
  end

  // update: level and second covering column
  always_comb begin
    upd_len  = rmst_pkg::IDX_W'(r_idx) - rmst_pkg::IDX_W'(l_idx) + rmst_pkg::IDX_W'(1);
    upd_lvl  = rmst_pkg::floor_log2(upd_len);
    upd_idx2 = rmst_pkg::IDX_W'(r_idx) + rmst_pkg::IDX_W'(1)
             - (rmst_pkg::IDX_W'(1) << upd_lvl);
  end

  // finalize: pushes level lvl into level lvl-1
  always_comb begin
    lvl_lo       = lvl - rmst_pkg::LVL_W'(1);
    fin_half     = rmst_pkg::IDX_W'(1) << lvl_lo;
    fin_tgt      = rmst_pkg::IDX_W'(jj) + fin_half;
    fin_has2     = fin_tgt < rmst_pkg::IDX_W'(eff_size);
    fin_last_col = (rmst_pkg::IDX_W'(jj) + rmst_pkg::IDX_W'(1))
                   == rmst_pkg::IDX_W'(eff_size);
    clr_last     = clr_addr == rmst_pkg::ADDR_W'(rmst_pkg::DEPTH - 1);
  end

  // RAM control per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_IDLE: begin
        ram_raddr = {rmst_pkg::LVL_W'(0), pos_m1[rmst_pkg::POS_W-1:0]};
      end
      S_UPD_RD1: begin
        ram_raddr = {upd_lvl, l_idx};
      end
      S_UPD_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = upd_addr1;
        ram_wdata = rmst_pkg::val_max(ram_rdata, upd_val);
        ram_raddr = upd_addr2;
      end
      S_UPD_WR2: begin
        // equal addresses read the pre-write word; max with the same value
        // gives the same result
        ram_we    = 1'b1;
        ram_waddr = upd_addr2;
        ram_wdata = rmst_pkg::val_max(ram_rdata, upd_val);
      end
      S_FIN_SRC: begin
        ram_raddr = {lvl, jj};
      end
      S_FIN_T1: begin
        ram_raddr = {lvl_lo, jj};
      end
      S_FIN_W1: begin
        ram_we    = 1'b1;
        ram_waddr = {lvl_lo, jj};
        ram_wdata = rmst_pkg::val_max(ram_rdata, fin_val);
        ram_raddr = {lvl_lo, fin_tgt[rmst_pkg::POS_W-1:0]};
      end
      S_FIN_W2: begin
        ram_we    = 1'b1;
        ram_waddr = {lvl_lo, fin_tgt[rmst_pkg::POS_W-1:0]};
        ram_wdata = rmst_pkg::val_max(ram_rdata, fin_val);
      end
      S_RD_WAIT, S_REPLY: begin
        ram_raddr = '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      clr_reply     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      size_in_use   <= rmst_pkg::SIZE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_in_use <= cfg_data;
      end
      // the reply state reloads the register on its own
      if (m_axis_tvalid && m_axis_tready && state != S_REPLY) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + rmst_pkg::ADDR_W'(1);
          if (clr_last) begin
            res_value  <= '0;
            res_status <= rmst_pkg::ST_OK;
            state      <= clr_reply ? S_REPLY : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            unique case (in_op)
              rmst_pkg::OP_UPDATE: begin
                l_idx   <= lo_m1[rmst_pkg::POS_W-1:0];
                r_idx   <= hi_m1[rmst_pkg::POS_W-1:0];
                upd_val <= in_val;
                if (ends_ok) begin
                  res_status <= rmst_pkg::ST_OK;
                  state      <= S_UPD_RD1;
                end else begin
                  res_status <= rmst_pkg::ST_REJECTED;
                  state      <= S_REPLY;
                end
              end
              rmst_pkg::OP_FINALIZE: begin
                res_status <= rmst_pkg::ST_OK;
                lvl        <= rmst_pkg::LVL_W'(rmst_pkg::NUM_LEVELS - 1);
                jj         <= '0;
                state      <= (eff_size == '0) ? S_REPLY : S_FIN_SRC;
              end
              rmst_pkg::OP_READ: begin
                if (pos_ok) begin
                  res_status <= rmst_pkg::ST_OK;
                  state      <= S_RD_WAIT;
                end else begin
                  res_status <= rmst_pkg::ST_REJECTED;
                  state      <= S_REPLY;
                end
              end
              rmst_pkg::OP_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              default: begin
                res_status <= rmst_pkg::ST_OK;
                state      <= S_REPLY;
              end
            endcase
          end
        end
        S_UPD_RD1: begin
          upd_addr1 <= {upd_lvl, l_idx};
          upd_addr2 <= {upd_lvl, upd_idx2[rmst_pkg::POS_W-1:0]};
          state     <= S_UPD_WR1;
        end
        S_UPD_WR1: begin
          state <= S_UPD_WR2;
        end
        S_UPD_WR2: begin
          state <= S_REPLY;
        end
        S_RD_WAIT: begin
          res_value <= ram_rdata;
          state     <= S_REPLY;
        end
        S_FIN_SRC: begin
          state <= S_FIN_T1;
        end
        S_FIN_T1: begin
          fin_val <= ram_rdata;
          state   <= S_FIN_W1;
        end
        S_FIN_W1, S_FIN_W2: begin
          if (state == S_FIN_W1 && fin_has2) begin
            state <= S_FIN_W2;
          end else if (!fin_last_col) begin
            jj    <= jj + rmst_pkg::POS_W'(1);
            state <= S_FIN_SRC;
          end else if (lvl_lo == '0) begin
            state <= S_REPLY;
          end else begin
            lvl   <= lvl_lo;
            jj    <= '0;
            state <= S_FIN_SRC;
          end
        end
        S_REPLY: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= rmst_pkg::M_TDATA_W'(res_value);
            m_axis_tuser  <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a stalled output register holds the sequencer in the reply state
  a_reply_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPLY && m_axis_tvalid && !m_axis_tready) |=> state == S_REPLY)
    else $error("reply left while output register was full");

  // an accepted read goes to the RAM wait or straight to a rejection
  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == rmst_pkg::OP_READ)
      |=> (state == S_RD_WAIT || state == S_REPLY))
    else $error("read request took a wrong path");

  // push-down never sources from level zero
  a_fin_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN_SRC || state == S_FIN_W1 || state == S_FIN_W2) |-> lvl != '0)
    else $error("push-down reached level zero as a source");

  // a raise never lowers the word: written value covers the update value
  a_raise_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD_WR1 || state == S_UPD_WR2) |-> (ram_we && ram_wdata >= upd_val))
    else $error("update write below its value");

endmodule

`default_nettype wire

FILE: hw/rtl/rmst_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none

module rmst_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the range-max update table: directed, size, pressure, random.
`timescale 1ns / 1ps

module testbench;
  import rmst_pkg::*;

  localparam int ITEMS_PER_PHASE = 500;
  localparam int SETTLE_CYCLES   = 20;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    status_t          status;
  } answer_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [OP_W-1:0]      s_axis_tuser  = OP_UPDATE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [FIELD_W-1:0]   cfg_data      = '0;

  // mirror of the table: [level][column], column 0 unused
  logic [VAL_W-1:0]   chmax_table [NUM_LEVELS][MAX_POSITIONS+1];
  logic [FIELD_W-1:0] size_reg = SIZE_RESET;
  answer_t            answer_queue [$];
  answer_t            front_answer;

  int error_count        = 0;
  int items_sent         = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_cycles_req    = 0;
  int hold_count         = 0;

  range_max_update_sparse_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #40_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_table();
    for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
      for (int col = 0; col <= MAX_POSITIONS; col++) begin
        chmax_table[lvl][col] = '0;
      end
    end
  endfunction

  function automatic void raise_cell(int unsigned lvl, int unsigned col,
                                     logic [VAL_W-1:0] v);
    if (lvl < NUM_LEVELS && col <= MAX_POSITIONS && chmax_table[lvl][col] < v) begin
      chmax_table[lvl][col] = v;
    end
  endfunction

  function automatic answer_t apply_to_table(op_t op, logic [FIELD_W-1:0] a,
                                             logic [FIELD_W-1:0] b,
                                             logic [RAISE_W-1:0] raise,
                                             logic [FIELD_W-1:0] pos);
    answer_t          ans;
    int unsigned      lim, lo, hi, lvl, len, half;
    logic [VAL_W-1:0] v;
    ans.read_value = '0;
    ans.status     = ST_OK;
    lim = (size_reg > MAX_POSITIONS) ? MAX_POSITIONS : size_reg;
    v   = raise[VAL_W-1:0];
    case (op)
      OP_UPDATE: begin
        if (a < 1 || a > lim || b < 1 || b > lim) begin
          ans.status = ST_REJECTED;
        end else begin
          lo  = (a < b) ? a : b;
          hi  = (a < b) ? b : a;
          len = hi - lo + 1;
          lvl = 0;
          while (len > 1) begin
            len = len >> 1;
            lvl++;
          end
          if (lvl >= NUM_LEVELS) lvl = NUM_LEVELS - 1;
          // two entries of width 2^lvl, one from each end, cover [lo, hi]
          raise_cell(lvl, lo, v);
          raise_cell(lvl, hi - (1 << lvl) + 1, v);
        end
      end
      OP_FINALIZE: begin
        for (int i = NUM_LEVELS - 1; i > 0; i--) begin
          half = 1 << (i - 1);
          for (int unsigned j = 1; j <= lim; j++) begin
            raise_cell(i - 1, j, chmax_table[i][j]);
            if (j + half <= lim) raise_cell(i - 1, j + half, chmax_table[i][j]);
          end
        end
      end
      OP_READ: begin
        if (pos < 1 || pos > lim) ans.status = ST_REJECTED;
        else ans.read_value = chmax_table[0][pos];
      end
      default: begin
        clear_table();
      end
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------- drivers

  always @(posedge clk) begin
    if (hold_cycles_req != 0) begin
      hold_count      = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_count != 0) begin
      hold_count--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (answer_queue.size() == 0) begin
        $display("%0t: result with nothing expected: read_value %0h status %0b",
                 $time, m_axis_tdata[VAL_W-1:0], m_axis_tuser);
        error_count++;
      end else begin
        front_answer = answer_queue.pop_front();
        if (m_axis_tdata[VAL_W-1:0] !== front_answer.read_value) begin
          $display("%0t: read_value mismatch: expected %0h actual %0h",
                   $time, front_answer.read_value, m_axis_tdata[VAL_W-1:0]);
          error_count++;
        end
        if (m_axis_tuser !== front_answer.status) begin
          $display("%0t: status mismatch: expected %0b actual %0b",
                   $time, front_answer.status, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // valid stays high after a request so back-to-back requests need no drop
  task automatic send_request(op_t op, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                              logic [RAISE_W-1:0] raise, logic [FIELD_W-1:0] pos);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= S_TDATA_W'({pos, raise, b, a});
    do @(posedge clk); while (!s_axis_tready);
    answer_queue.push_back(apply_to_table(op, a, b, raise, pos));
    items_sent++;
  endtask

  task automatic do_update(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                           logic [RAISE_W-1:0] v);
    send_request(OP_UPDATE, a, b, v, FIELD_W'($urandom));
  endtask

  task automatic do_read(logic [FIELD_W-1:0] pos);
    send_request(OP_READ, FIELD_W'($urandom), FIELD_W'($urandom), $urandom, pos);
  endtask

  // finalize or clear, with junk in the unused fields
  task automatic do_plain(op_t op);
    send_request(op, FIELD_W'($urandom), FIELD_W'($urandom), $urandom, FIELD_W'($urandom));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (answer_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [FIELD_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    size_reg = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly in 1..lim, now and then any 11-bit value
  function automatic logic [FIELD_W-1:0] pick_index(int unsigned lim);
    if (lim == 0 || $urandom_range(15) == 0) return FIELD_W'($urandom);
    return FIELD_W'($urandom_range(lim, 1));
  endfunction

  function automatic logic [RAISE_W-1:0] pick_raise();
    return $urandom_range(1) ? $urandom : $urandom_range(255);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    write_size(SIZE_RESET);
    do_read(1);                          // zero after the reset sweep
    do_update(1, 1024, 32'hC000_0010);   // full span, bits above 30 dropped
    do_update(1024, 1, 32'd5);           // endpoints reversed
    do_update(7, 7, 32'h1234_5678);      // length one goes straight to level 0
    do_update(10, 3, 32'h0000_0F00);     // length 8
    do_update(0, 5, 32'h3FFF_FFFF);      // endpoint below range
    do_update(5, 1025, 32'h3FFF_FFFF);   // endpoint above range
    do_update(2047, 3, 32'h3FFF_FFFF);
    do_read(7);                          // before any push-down
    do_plain(OP_FINALIZE);
    do_read(1);
    do_read(1024);
    do_read(7);
    do_read(5);
    do_read(600);
    do_read(0);
    do_read(1025);
    do_read(2047);
    do_update(500, 520, 32'h2AAA_AAAA);  // update after finalize
    do_plain(OP_FINALIZE);               // second finalize
    do_read(510);
    do_plain(OP_CLEAR);
    do_read(1024);
  endtask

  task automatic test_size_limits();
    write_size(11'd0);                   // nothing is in range
    do_update(1, 1, 32'd9);
    do_read(1);
    do_plain(OP_FINALIZE);
    write_size(11'h7FF);                 // limited to the table size
    do_update(1024, 1024, 32'h0BAD_CAFE);
    do_read(1024);
    do_read(1025);
    write_size(11'd1);
    do_update(1, 1, 32'd77);
    do_update(1, 2, 32'd99);
    do_plain(OP_FINALIZE);
    do_read(1);
    do_read(2);
    // finalize at a small size leaves columns past it alone
    write_size(11'd1024);
    do_update(1, 1024, 32'h0ABC_DEF0);
    write_size(11'd16);
    do_plain(OP_FINALIZE);
    do_read(9);
    do_read(16);
    write_size(11'd1024);
    do_read(1000);
    do_read(9);
  endtask

  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    write_size(11'd64);
    hold_cycles_req = 400;
    @(posedge clk);
    repeat (6) do_update(pick_index(64), pick_index(64), pick_raise());
    repeat (6) do_read(pick_index(64));
    // sender waits for every result before going on
    drain_results();
    do_plain(OP_FINALIZE);
    repeat (8) do_read(pick_index(64));
  endtask

  task automatic run_episode();
    int unsigned        pick, lim;
    logic [FIELD_W-1:0] new_size;
    pick = $urandom_range(99);
    if (pick < 3) new_size = $urandom_range(1) ? 11'd1024 : 11'h7FF;
    else if (pick < 6) new_size = $urandom_range(1) ? 11'd0 : 11'd1;
    else if (pick < 12) new_size = FIELD_W'($urandom_range(300, 49));
    else new_size = FIELD_W'($urandom_range(48, 1));
    write_size(new_size);
    lim = (new_size > MAX_POSITIONS) ? MAX_POSITIONS : new_size;
    if ($urandom_range(7) == 0) do_plain(OP_CLEAR);
    repeat ($urandom_range(12, 1)) begin
      if ($urandom_range(9) == 0) begin
        send_request(op_t'($urandom_range(1) ? OP_READ : OP_UPDATE), FIELD_W'($urandom),
                     FIELD_W'($urandom), $urandom, FIELD_W'($urandom));
      end else begin
        do_update(pick_index(lim), pick_index(lim), pick_raise());
      end
    end
    do_plain(OP_FINALIZE);
    repeat ($urandom_range(16, 4)) do_read(pick_index(lim));
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(4, 1)) do_update(pick_index(lim), pick_index(lim), pick_raise());
      if ($urandom_range(1)) do_plain(OP_FINALIZE);
      repeat ($urandom_range(6, 1)) do_read(pick_index(lim));
    end
  endtask

  task automatic test_random();
    int start;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
        default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) run_episode();
    end
  endtask

  initial begin
    clear_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_size_limits();
    test_backpressure();
    test_random();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
